// ===== rtl/u8pt_pkg.sv =====
// shared types, constants and codepoint class tables for the pre-token splitter
package u8pt_pkg;

    localparam int OFFSET_BITS_DEF    = 32;
    localparam int MAX_NUMBER_RUN_DEF = 3;
    localparam int UNIT_MAX           = 4;
    localparam int PIECE_MAX          = 8;
    localparam int PIECE_CNT_W        = $clog2(PIECE_MAX + 1);
    localparam int CP_W               = 21;

    typedef enum logic [2:0] {
        K_CONTRACT = 3'd0,
        K_LETTERS  = 3'd1,
        K_PREFIXED = 3'd2,
        K_NUMBERS  = 3'd3,
        K_OTHERS   = 3'd4,
        K_WHITE    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        t_kind       kind;
        logic        done;
        logic        last;
    } t_piece;

    typedef struct packed {
        logic [PIECE_CNT_W-1:0]  count;
        t_piece [PIECE_MAX-1:0]  pieces;
    } t_batch;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
    } t_unit;

    function automatic logic cp_alpha(input logic [CP_W-1:0] c);
        return c inside {[21'h41:21'h5A], [21'h61:21'h7A], 21'hAA, 21'hB5, 21'hBA,
            [21'hC0:21'hD6], [21'hD8:21'hF6], [21'hF8:21'h2C1], [21'h400:21'h481],
            [21'h48A:21'h52F], [21'h620:21'h64A], [21'h66E:21'h66F], [21'h671:21'h6D3],
            [21'h6E5:21'h6E6], [21'h6EE:21'h6EF], [21'h6FA:21'h6FC], 21'h6FF,
            [21'h904:21'h939], 21'h93D, 21'h950, [21'h958:21'h961],
            [21'h3041:21'h3096], [21'h309D:21'h309F], [21'h30A1:21'h30FA],
            [21'h30FC:21'h30FF], [21'h3400:21'h4DBF], [21'h4E00:21'h9FFF],
            [21'hAC00:21'hD7A3]};
    endfunction

    function automatic logic cp_digit(input logic [CP_W-1:0] c);
        return c inside {[21'h30:21'h39], [21'h660:21'h669], [21'h6F0:21'h6F9],
            [21'h966:21'h96F], [21'hFF10:21'hFF19], [21'h1D7CE:21'h1D7FF]};
    endfunction

    function automatic logic is_white(input logic [CP_W-1:0] c);
        return c inside {[21'h2000:21'h200A], 21'h20, 21'h09, 21'h0A, 21'h0D, 21'h0B,
            21'h0C, 21'h85, 21'hA0, 21'h1680, 21'h2028, 21'h2029, 21'h202F, 21'h205F,
            21'h3000};
    endfunction

    function automatic logic is_nl(input logic [CP_W-1:0] c);
        return (c == 21'h0A) || (c == 21'h0D);
    endfunction

    function automatic logic cp_misc(input logic [CP_W-1:0] c);
        return !cp_alpha(c) && !cp_digit(c) && !is_white(c);
    endfunction

    function automatic logic [CP_W-1:0] lower_ascii(input logic [CP_W-1:0] c);
        return (c >= 21'h41 && c <= 21'h5A) ? c + 21'h20 : c;
    endfunction

endpackage

// ===== rtl/u8pt_decoder.sv =====
// utf-8 byte window and unit extraction with saturating byte offsets
module u8pt_decoder #(
    parameter int OFFSET_BITS = u8pt_pkg::OFFSET_BITS_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_accept,
    input  logic [7:0]                                       i_byte,
    input  logic                                             i_final,
    output u8pt_pkg::t_unit [u8pt_pkg::UNIT_MAX-1:0]          o_units,
    output logic [u8pt_pkg::UNIT_MAX-1:0][OFFSET_BITS-1:0]    o_unit_s,
    output logic [u8pt_pkg::UNIT_MAX-1:0][OFFSET_BITS-1:0]    o_unit_e
);
    import u8pt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [2:0][7:0]         r_win;
    logic [1:0]              r_cnt;
    logic [OFFSET_BITS-1:0]  r_base;
    logic [OFFSET_BITS-1:0]  r_offset;

    logic [2:0][7:0]         n_win;
    logic [1:0]              n_cnt;
    logic [OFFSET_BITS-1:0]  n_base;

    logic [3:0][7:0]         w;
    logic [2:0]              rem;
    logic [2:0]              usz;
    logic                    stop;
    logic [OFFSET_BITS-1:0]  base;

    function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [2:0] b);
        logic [OFFSET_BITS:0] r;
        r = {1'b0, a} + {{(OFFSET_BITS - 2){1'b0}}, b};
        return r[OFFSET_BITS] ? OFF_MAX : r[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [2:0] unit_size(input logic [3:0][7:0] b, input logic [2:0] n,
                                             input logic fin);
        logic [2:0] need;
        logic [7:0] cb;
        if (n == 3'd0) return 3'd0;
        if (!b[0][7]) return 3'd1;
        if (b[0] >= 8'hC2 && b[0] <= 8'hDF) need = 3'd2;
        else if (b[0] >= 8'hE0 && b[0] <= 8'hEF) need = 3'd3;
        else if (b[0] >= 8'hF0 && b[0] <= 8'hF4) need = 3'd4;
        else return 3'd1;
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < need) begin
                if (3'(i) >= n) return fin ? 3'd1 : 3'd0;
                cb = b[2'(i)];
                if (cb[7:6] != 2'b10) return 3'd1;
                if (i == 1) begin
                    if (b[0] == 8'hE0 && cb < 8'hA0) return 3'd1;
                    if (b[0] == 8'hED && cb > 8'h9F) return 3'd1;
                    if (b[0] == 8'hF0 && cb < 8'h90) return 3'd1;
                    if (b[0] == 8'hF4 && cb > 8'h8F) return 3'd1;
                end
            end
        end
        return need;
    endfunction

    function automatic logic [CP_W-1:0] unit_value(input logic [3:0][7:0] b,
                                                   input logic [2:0] n);
        case (n)
            3'd2:    return {10'b0, b[0][4:0], b[1][5:0]};
            3'd3:    return {5'b0, b[0][3:0], b[1][5:0], b[2][5:0]};
            3'd4:    return {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: return {13'b0, b[0]};
        endcase
    endfunction

    always_comb begin
        w        = {8'h00, r_win};
        w[r_cnt] = i_byte;
        rem      = {1'b0, r_cnt} + 3'd1;
        base     = (r_cnt == 2'd0) ? r_offset : r_base;
        stop     = 1'b0;
        usz      = 3'd0;
        for (int k = 0; k < UNIT_MAX; k++) begin
            o_units[k]  = '0;
            o_unit_s[k] = base;
            o_unit_e[k] = base;
            if (!stop) begin
                usz = unit_size(w, rem, i_final);
                if (usz == 3'd0) begin
                    stop = 1'b1;
                end else begin
                    o_units[k].valid = 1'b1;
                    o_units[k].cp    = unit_value(w, usz);
                    o_unit_e[k]      = sat_add(base, usz);
                    base             = o_unit_e[k];
                    w                = w >> {usz, 3'b000};
                    rem              = rem - usz;
                end
            end
        end
        n_win  = w[2:0];
        n_cnt  = i_final ? 2'd0 : rem[1:0];
        n_base = i_final ? '0 : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_base   <= '0;
            r_offset <= '0;
        end else if (i_accept) begin
            r_cnt    <= n_cnt;
            r_base   <= n_base;
            r_offset <= i_final ? '0 : sat_add(r_offset, 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== rtl/u8pt_splitter.sv =====
// pre-token split state machine, turns decoded units into a batch of pieces
module u8pt_splitter #(
    parameter int OFFSET_BITS    = u8pt_pkg::OFFSET_BITS_DEF,
    parameter int MAX_NUMBER_RUN = u8pt_pkg::MAX_NUMBER_RUN_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_accept,
    input  logic                                             i_final,
    input  u8pt_pkg::t_unit [u8pt_pkg::UNIT_MAX-1:0]          i_units,
    input  logic [u8pt_pkg::UNIT_MAX-1:0][OFFSET_BITS-1:0]    i_unit_s,
    input  logic [u8pt_pkg::UNIT_MAX-1:0][OFFSET_BITS-1:0]    i_unit_e,
    output u8pt_pkg::t_batch                                  o_batch
);
    import u8pt_pkg::*;

    localparam int NC_W = $clog2(MAX_NUMBER_RUN + 1);
    localparam int OB   = OFFSET_BITS;

    typedef enum logic [8:0] {
        M_IDLE      = 9'b000000001,
        M_LETTERS   = 9'b000000010,
        M_NUMBERS   = 9'b000000100,
        M_OTHERS    = 9'b000001000,
        M_OTHERS_NL = 9'b000010000,
        M_OPEND     = 9'b000100000,
        M_APOS      = 9'b001000000,
        M_APOS2     = 9'b010000000,
        M_WS        = 9'b100000000
    } t_mode;

    typedef struct packed {
        t_mode           mode;
        logic            prefixed;
        logic [OB-1:0]   pbeg;
        logic [OB-1:0]   pend;
        logic [OB-1:0]   nl_end;
        logic            nl_seen;
        logic [OB-1:0]   tail_start;
        logic [1:0]      tail_count;
        logic            tail_space;
        logic            held_l;
        logic [NC_W-1:0] ncount;
    } t_state;

    typedef struct packed {
        t_state                  st;
        logic [PIECE_CNT_W-1:0]  n;
        t_piece [PIECE_MAX-1:0]  p;
        logic                    again;
    } t_ctx;

    localparam t_state RESET_ST = '{mode: M_IDLE, default: '0};

    t_state r_st;
    t_state n_st;
    t_ctx   ctx;

    function automatic logic [31:0] sat32(input logic [OB-1:0] v);
        logic [63:0] x;
        x = 64'(v);
        return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic t_ctx emit(input t_ctx x, input logic [OB-1:0] s,
                                  input logic [OB-1:0] e, input t_kind k);
        t_ctx y;
        logic [OB-1:0] d;
        y = x;
        d = (e >= s) ? e - s : '0;
        if (x.n < PIECE_CNT_W'(PIECE_MAX)) begin
            y.p[x.n[$clog2(PIECE_MAX)-1:0]] = '{start: sat32(s), length: sat32(d), kind: k,
                                                 done: 1'b0, last: 1'b0};
            y.n = x.n + 1'b1;
        end
        return y;
    endfunction

    function automatic t_ctx ws_add(input t_ctx x, input logic [CP_W-1:0] c,
                                    input logic [OB-1:0] s, input logic [OB-1:0] e);
        t_ctx y;
        y = x;
        y.st.pend = e;
        if (is_nl(c)) begin
            y.st.nl_end     = e;
            y.st.nl_seen    = 1'b1;
            y.st.tail_count = 2'd0;
        end else begin
            if (x.st.tail_count == 2'd0) begin
                y.st.tail_start = s;
                y.st.tail_space = (c == 21'h20);
            end
            if (x.st.tail_count < 2'd2) y.st.tail_count = x.st.tail_count + 2'd1;
        end
        return y;
    endfunction

    function automatic t_ctx begin_fresh(input t_ctx x, input logic [CP_W-1:0] c,
                                         input logic [OB-1:0] s, input logic [OB-1:0] e);
        t_ctx y;
        y = x;
        y.st.pbeg = s;
        y.st.pend = e;
        if (c == 21'h27) begin
            y.st.mode = M_APOS;
        end else if (cp_alpha(c)) begin
            y.st.mode     = M_LETTERS;
            y.st.prefixed = 1'b0;
        end else if (cp_digit(c)) begin
            y.st.ncount = NC_W'(1);
            y.st.mode   = M_NUMBERS;
            if (MAX_NUMBER_RUN <= 1) begin
                y         = emit(y, s, e, K_NUMBERS);
                y.st.mode = M_IDLE;
            end
        end else if (is_white(c)) begin
            y.st.mode       = M_WS;
            y.st.nl_seen    = 1'b0;
            y.st.tail_count = 2'd0;
            y               = ws_add(y, c, s, e);
        end else begin
            y.st.mode = M_OPEND;
        end
        return y;
    endfunction

    function automatic t_ctx ws_finish(input t_ctx x, input logic has_next,
                                       input logic [CP_W-1:0] c,
                                       input logic [OB-1:0] s, input logic [OB-1:0] e);
        t_ctx y;
        logic fresh;
        y = x;
        fresh = has_next;
        if (y.st.nl_seen) y = emit(y, y.st.pbeg, y.st.nl_end, K_WHITE);
        y.st.mode = M_IDLE;
        if (y.st.tail_count >= 2'd2) begin
            y = emit(y, y.st.tail_start, y.st.pend, K_WHITE);
        end else if (y.st.tail_count == 2'd1) begin
            if (has_next && cp_alpha(c)) begin
                y.st.pbeg     = y.st.tail_start;
                y.st.pend     = e;
                y.st.mode     = M_LETTERS;
                y.st.prefixed = 1'b1;
                fresh         = 1'b0;
            end else if (has_next && y.st.tail_space && cp_misc(c)) begin
                y.st.pbeg = y.st.tail_start;
                y.st.pend = e;
                y.st.mode = M_OTHERS;
                fresh     = 1'b0;
            end else begin
                y = emit(y, y.st.tail_start, y.st.pend, K_WHITE);
            end
        end
        if (fresh) y = begin_fresh(y, c, s, e);
        return y;
    endfunction

    function automatic t_ctx feed_once(input t_ctx x, input logic [CP_W-1:0] c,
                                       input logic [OB-1:0] s, input logic [OB-1:0] e);
        t_ctx y;
        logic fresh;
        logic [CP_W-1:0] lc;
        y = x;
        y.again = 1'b0;
        fresh = 1'b0;
        lc = lower_ascii(c);
        unique case (x.st.mode)
            M_LETTERS: begin
                if (cp_alpha(c)) begin
                    y.st.pend = e;
                end else begin
                    y = emit(y, y.st.pbeg, y.st.pend, y.st.prefixed ? K_PREFIXED : K_LETTERS);
                    fresh = 1'b1;
                end
            end
            M_NUMBERS: begin
                if (cp_digit(c)) begin
                    y.st.pend   = e;
                    y.st.ncount = x.st.ncount + 1'b1;
                    if (y.st.ncount >= NC_W'(MAX_NUMBER_RUN)) begin
                        y         = emit(y, y.st.pbeg, e, K_NUMBERS);
                        y.st.mode = M_IDLE;
                    end
                end else begin
                    y = emit(y, y.st.pbeg, y.st.pend, K_NUMBERS);
                    fresh = 1'b1;
                end
            end
            M_OTHERS: begin
                if (cp_misc(c)) begin
                    y.st.pend = e;
                end else if (is_nl(c)) begin
                    y.st.pend = e;
                    y.st.mode = M_OTHERS_NL;
                end else begin
                    y = emit(y, y.st.pbeg, y.st.pend, K_OTHERS);
                    fresh = 1'b1;
                end
            end
            M_OTHERS_NL: begin
                if (is_nl(c)) begin
                    y.st.pend = e;
                end else begin
                    y = emit(y, y.st.pbeg, y.st.pend, K_OTHERS);
                    fresh = 1'b1;
                end
            end
            M_APOS: begin
                if (lc == 21'h73 || lc == 21'h74 || lc == 21'h6D || lc == 21'h64) begin
                    y         = emit(y, y.st.pbeg, e, K_CONTRACT);
                    y.st.mode = M_IDLE;
                end else if (lc == 21'h72 || lc == 21'h76 || lc == 21'h6C) begin
                    y.st.held_l = (lc == 21'h6C);
                    y.st.pend   = e;
                    y.st.mode   = M_APOS2;
                end else begin
                    y.st.mode = M_OPEND;
                    y.again   = 1'b1;
                end
            end
            M_APOS2: begin
                if (x.st.held_l ? (lc == 21'h6C) : (lc == 21'h65)) begin
                    y         = emit(y, y.st.pbeg, e, K_CONTRACT);
                    y.st.mode = M_IDLE;
                end else begin
                    y.st.mode     = M_LETTERS;
                    y.st.prefixed = 1'b1;
                    y.again       = 1'b1;
                end
            end
            M_OPEND: begin
                if (cp_alpha(c)) begin
                    y.st.pend     = e;
                    y.st.mode     = M_LETTERS;
                    y.st.prefixed = 1'b1;
                end else begin
                    y.st.mode = M_OTHERS;
                    y.again   = 1'b1;
                end
            end
            M_WS: begin
                if (is_white(c)) y = ws_add(y, c, s, e);
                else y = ws_finish(y, 1'b1, c, s, e);
            end
            M_IDLE:  fresh = 1'b1;
            default: fresh = 1'b1;
        endcase
        if (fresh) begin
            y.st.mode = M_IDLE;
            y = begin_fresh(y, c, s, e);
        end
        return y;
    endfunction

    function automatic t_ctx feed(input t_ctx x, input logic [CP_W-1:0] c,
                                  input logic [OB-1:0] s, input logic [OB-1:0] e);
        t_ctx y;
        y = x;
        y.again = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (y.again) y = feed_once(y, c, s, e);
        end
        return y;
    endfunction

    function automatic t_ctx flush(input t_ctx x);
        t_ctx y;
        y = x;
        unique case (x.st.mode) inside
            M_LETTERS: y = emit(y, y.st.pbeg, y.st.pend,
                                y.st.prefixed ? K_PREFIXED : K_LETTERS);
            M_NUMBERS: y = emit(y, y.st.pbeg, y.st.pend, K_NUMBERS);
            M_OTHERS, M_OTHERS_NL, M_OPEND, M_APOS:
                y = emit(y, y.st.pbeg, y.st.pend, K_OTHERS);
            M_APOS2:   y = emit(y, y.st.pbeg, y.st.pend, K_PREFIXED);
            M_WS:      y = ws_finish(y, 1'b0, '0, '0, '0);
            default:   y.st.mode = M_IDLE;
        endcase
        y.st.mode = M_IDLE;
        return y;
    endfunction

    always_comb begin
        ctx    = '0;
        ctx.st = r_st;
        for (int k = 0; k < UNIT_MAX; k++) begin
            if (i_units[k].valid) ctx = feed(ctx, i_units[k].cp, i_unit_s[k], i_unit_e[k]);
        end
        if (i_final) ctx = flush(ctx);
        for (int i = 0; i < PIECE_MAX; i++) begin
            if (ctx.n != '0 && PIECE_CNT_W'(i) == ctx.n - 1'b1) begin
                ctx.p[i].last = 1'b1;
                ctx.p[i].done = i_final;
            end
        end
        o_batch.count  = ctx.n;
        o_batch.pieces = ctx.p;
        n_st = i_final ? RESET_ST : ctx.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= RESET_ST;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

// ===== rtl/u8pt_result_buf.sv =====
// result register bank, loaded with one batch and drained one word per cycle while words are taken
module u8pt_result_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8pt_pkg::t_batch  i_batch,
    input  logic              i_taken,
    output logic              o_ready,
    output logic              o_valid,
    output u8pt_pkg::t_piece  o_piece
);
    import u8pt_pkg::*;

    t_piece [PIECE_MAX-1:0]  r_q;
    logic [PIECE_CNT_W-1:0]  r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_piece = r_q[0];
    assign o_ready = (r_cnt == '0) || (r_cnt == PIECE_CNT_W'(1) && i_taken);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
        end else if (o_valid && i_taken) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_batch.pieces;
        end else if (o_valid && i_taken) begin
            for (int i = 0; i < PIECE_MAX - 1; i++) r_q[i] <= r_q[i + 1];
        end
    end

endmodule

// ===== rtl/utf8_pretoken_splitter.sv =====
// top level: utf-8 byte stream in, pre-token pieces out
// output: the first piece of a byte appears on the output in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one piece and the output
// is not stalled; a byte with more (up to 8) stalls input until its last piece is taken
// reset: synchronous active low, clears offsets, window count, split state and the output
// bank at once; the byte window needs no clearing
module utf8_pretoken_splitter #(
    parameter int OFFSET_BITS    = u8pt_pkg::OFFSET_BITS_DEF,
    parameter int MAX_NUMBER_RUN = u8pt_pkg::MAX_NUMBER_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // piece_start, piece_length, piece_kind, zero fill
    output logic        o_m_tlast,   // text_done
    output logic [0:0]  o_m_tuser    // last_of_run
);
    import u8pt_pkg::*;

    logic                                   accept;
    t_unit [UNIT_MAX-1:0]                   units;
    logic [UNIT_MAX-1:0][OFFSET_BITS-1:0]   unit_s;
    logic [UNIT_MAX-1:0][OFFSET_BITS-1:0]   unit_e;
    t_batch                                 batch;
    t_piece                                 piece;

    assign accept = i_s_tvalid && o_s_tready;

    u8pt_decoder #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_final  (i_s_tlast),
        .o_units  (units),
        .o_unit_s (unit_s),
        .o_unit_e (unit_e)
    );

    u8pt_splitter #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_NUMBER_RUN (MAX_NUMBER_RUN)
    ) u_splitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_final  (i_s_tlast),
        .i_units  (units),
        .i_unit_s (unit_s),
        .i_unit_e (unit_e),
        .o_batch  (batch)
    );

    u8pt_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_batch (batch),
        .i_taken (i_m_tready),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_piece (piece)
    );

    assign o_m_tdata = {5'b0, piece.kind, piece.length, piece.start};
    assign o_m_tlast = piece.done;
    assign o_m_tuser = piece.last;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while a result word is stalled");

    a_empty_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("empty result bank not ready for input");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[0])
        else $error("text end word not marked last of its byte");
`endif

endmodule

// ===== tb/utf8_pretoken_splitter_tb.sv =====
// testbench for the utf-8 pre-token splitter: directed and random text against a local predictor
`timescale 1ns / 1ps

module utf8_pretoken_splitter_tb;
    import u8pt_pkg::*;

    localparam longint unsigned OFF_TOP   = 64'hFFFF_FFFF;
    localparam int              CYCLE_CAP = 2_000_000;

    typedef enum int {
        SP_IDLE, SP_LETTERS, SP_NUMBERS, SP_OTHERS, SP_OTHERS_NL, SP_OPEN, SP_APOS, SP_APOS2, SP_WS
    } t_split;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;  // in_byte
    logic        i_s_tlast = 1'b0;   // end_of_text
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;          // piece_start, piece_length, piece_kind, zero fill
    logic        o_m_tlast;          // text_done
    logic [0:0]  o_m_tuser;          // last_of_run

    utf8_pretoken_splitter i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int     fail_count = 0;
    int     cycle_count = 0;
    int     sent_words = 0;
    bit     no_idle = 1'b0;
    t_piece pending_pieces[$];
    t_piece step_pieces[$];

    // splitter state
    logic [7:0]      win[8];
    int              win_cnt;
    longint unsigned win_base, byte_pos, pc_begin, pc_end, nl_end, tail_start;
    t_split          mode;
    t_kind           letter_kind;
    bit              nl_seen, tail_space;
    int              tail_cnt, num_cnt;
    int unsigned     held;

    function automatic bit cls_letter(int unsigned c);
        return c inside {[32'h41:32'h5A], [32'h61:32'h7A], 32'hAA, 32'hB5, 32'hBA,
            [32'hC0:32'hD6], [32'hD8:32'hF6], [32'hF8:32'h2C1], [32'h400:32'h481],
            [32'h48A:32'h52F], [32'h620:32'h64A], [32'h66E:32'h66F], [32'h671:32'h6D3],
            [32'h6E5:32'h6E6], [32'h6EE:32'h6EF], [32'h6FA:32'h6FC], 32'h6FF,
            [32'h904:32'h939], 32'h93D, 32'h950, [32'h958:32'h961],
            [32'h3041:32'h3096], [32'h309D:32'h309F], [32'h30A1:32'h30FA],
            [32'h30FC:32'h30FF], [32'h3400:32'h4DBF], [32'h4E00:32'h9FFF],
            [32'hAC00:32'hD7A3]};
    endfunction

    function automatic bit cls_number(int unsigned c);
        return c inside {[32'h30:32'h39], [32'h660:32'h669], [32'h6F0:32'h6F9],
            [32'h966:32'h96F], [32'hFF10:32'hFF19], [32'h1D7CE:32'h1D7FF]};
    endfunction

    function automatic bit cls_white(int unsigned c);
        return c inside {[32'h2000:32'h200A], 32'h20, 32'h09, 32'h0A, 32'h0D, 32'h0B,
            32'h0C, 32'h85, 32'hA0, 32'h1680, 32'h2028, 32'h2029, 32'h202F, 32'h205F,
            32'h3000};
    endfunction

    function automatic bit cls_nl(int unsigned c);
        return c == 32'h0A || c == 32'h0D;
    endfunction

    function automatic bit cls_other(int unsigned c);
        return !cls_letter(c) && !cls_number(c) && !cls_white(c);
    endfunction

    function automatic int unsigned fold_case(int unsigned c);
        return (c >= 32'h41 && c <= 32'h5A) ? c + 32'h20 : c;
    endfunction

    function automatic longint unsigned sat_inc(longint unsigned a, longint unsigned b);
        longint unsigned r;
        r = a + b;
        return (r < a || r > OFF_TOP) ? OFF_TOP : r;
    endfunction

    function automatic void add_piece(longint unsigned s, longint unsigned e, t_kind k);
        t_piece p;
        longint unsigned len;
        if (step_pieces.size() >= PIECE_MAX) return;
        len = (e >= s) ? e - s : 0;
        p.start  = (s > OFF_TOP) ? 32'hFFFF_FFFF : s[31:0];
        p.length = (len > OFF_TOP) ? 32'hFFFF_FFFF : len[31:0];
        p.kind   = k;
        p.done   = 1'b0;
        p.last   = 1'b0;
        step_pieces.insert(step_pieces.size(), p);
    endfunction

    function automatic void ws_take(int unsigned c, longint unsigned s, longint unsigned e);
        pc_end = e;
        if (cls_nl(c)) begin
            nl_end = e;
            nl_seen = 1'b1;
            tail_cnt = 0;
        end else begin
            if (tail_cnt == 0) begin
                tail_start = s;
                tail_space = (c == 32'h20);
            end
            if (tail_cnt < 2) tail_cnt++;
        end
    endfunction

    function automatic void open_piece(int unsigned c, longint unsigned s, longint unsigned e);
        pc_begin = s;
        pc_end = e;
        if (c == 32'h27) begin
            mode = SP_APOS;
        end else if (cls_letter(c)) begin
            mode = SP_LETTERS;
            letter_kind = K_LETTERS;
        end else if (cls_number(c)) begin
            num_cnt = 1;
            mode = SP_NUMBERS;
            if (num_cnt >= MAX_NUMBER_RUN_DEF) begin
                add_piece(s, e, K_NUMBERS);
                mode = SP_IDLE;
            end
        end else if (cls_white(c)) begin
            mode = SP_WS;
            nl_seen = 1'b0;
            tail_cnt = 0;
            ws_take(c, s, e);
        end else begin
            mode = SP_OPEN;
        end
    endfunction

    function automatic void ws_close(bit has_next, int unsigned c, longint unsigned s,
                                     longint unsigned e);
        if (nl_seen) add_piece(pc_begin, nl_end, K_WHITE);
        mode = SP_IDLE;
        if (tail_cnt >= 2) begin
            add_piece(tail_start, pc_end, K_WHITE);
        end else if (tail_cnt == 1) begin
            if (has_next && cls_letter(c)) begin
                pc_begin = tail_start;
                pc_end = e;
                mode = SP_LETTERS;
                letter_kind = K_PREFIXED;
                return;
            end
            if (has_next && tail_space && cls_other(c)) begin
                pc_begin = tail_start;
                pc_end = e;
                mode = SP_OTHERS;
                return;
            end
            add_piece(tail_start, pc_end, K_WHITE);
        end
        if (has_next) open_piece(c, s, e);
    endfunction

    function automatic void take_unit(int unsigned c, longint unsigned s, longint unsigned e);
        int unsigned lc;
        case (mode)
            SP_LETTERS: begin
                if (cls_letter(c)) begin
                    pc_end = e;
                    return;
                end
                add_piece(pc_begin, pc_end, letter_kind);
            end
            SP_NUMBERS: begin
                if (cls_number(c)) begin
                    pc_end = e;
                    num_cnt++;
                    if (num_cnt >= MAX_NUMBER_RUN_DEF) begin
                        add_piece(pc_begin, e, K_NUMBERS);
                        mode = SP_IDLE;
                    end
                    return;
                end
                add_piece(pc_begin, pc_end, K_NUMBERS);
            end
            SP_OTHERS: begin
                if (cls_other(c)) begin
                    pc_end = e;
                    return;
                end
                if (cls_nl(c)) begin
                    pc_end = e;
                    mode = SP_OTHERS_NL;
                    return;
                end
                add_piece(pc_begin, pc_end, K_OTHERS);
            end
            SP_OTHERS_NL: begin
                if (cls_nl(c)) begin
                    pc_end = e;
                    return;
                end
                add_piece(pc_begin, pc_end, K_OTHERS);
            end
            SP_APOS: begin
                lc = fold_case(c);
                if (lc inside {"s", "t", "m", "d"}) begin
                    add_piece(pc_begin, e, K_CONTRACT);
                    mode = SP_IDLE;
                    return;
                end
                if (lc inside {"r", "v", "l"}) begin
                    held = lc;
                    pc_end = e;
                    mode = SP_APOS2;
                    return;
                end
                mode = SP_OPEN;
                take_unit(c, s, e);
                return;
            end
            SP_APOS2: begin
                lc = fold_case(c);
                if ((held == "r" && lc == "e") || (held == "v" && lc == "e") ||
                    (held == "l" && lc == "l")) begin
                    add_piece(pc_begin, e, K_CONTRACT);
                    mode = SP_IDLE;
                    return;
                end
                mode = SP_LETTERS;
                letter_kind = K_PREFIXED;
                take_unit(c, s, e);
                return;
            end
            SP_OPEN: begin
                if (cls_letter(c)) begin
                    pc_end = e;
                    mode = SP_LETTERS;
                    letter_kind = K_PREFIXED;
                    return;
                end
                mode = SP_OTHERS;
                take_unit(c, s, e);
                return;
            end
            SP_WS: begin
                if (cls_white(c)) ws_take(c, s, e);
                else ws_close(1'b1, c, s, e);
                return;
            end
            default: ;
        endcase
        mode = SP_IDLE;
        open_piece(c, s, e);
    endfunction

    function automatic int unit_len(bit fin);
        int need;
        logic [7:0] b0, b;
        if (win_cnt == 0) return 0;
        b0 = win[0];
        if (b0 < 8'h80) return 1;
        if (b0 >= 8'hC2 && b0 <= 8'hDF) need = 2;
        else if (b0 >= 8'hE0 && b0 <= 8'hEF) need = 3;
        else if (b0 >= 8'hF0 && b0 <= 8'hF4) need = 4;
        else return 1;
        for (int i = 1; i < need; i++) begin
            if (i >= win_cnt) return fin ? 1 : 0;
            b = win[i];
            if ((b & 8'hC0) != 8'h80) return 1;
            if (i == 1) begin
                if (b0 == 8'hE0 && b < 8'hA0) return 1;
                if (b0 == 8'hED && b > 8'h9F) return 1;
                if (b0 == 8'hF0 && b < 8'h90) return 1;
                if (b0 == 8'hF4 && b > 8'h8F) return 1;
            end
        end
        return need;
    endfunction

    function automatic int unsigned unit_cp(int n);
        int unsigned b0, b1, b2, b3;
        b0 = win[0];
        b1 = win[1] & 8'h3F;
        b2 = win[2] & 8'h3F;
        b3 = win[3] & 8'h3F;
        if (n == 2) return ((b0 & 32'h1F) << 6) | b1;
        if (n == 3) return ((b0 & 32'h0F) << 12) | (b1 << 6) | b2;
        if (n == 4) return ((b0 & 32'h07) << 18) | (b1 << 12) | (b2 << 6) | b3;
        return b0;
    endfunction

    function automatic void clear_splitter();
        foreach (win[i]) win[i] = 8'h00;
        win_cnt = 0;
        win_base = 0;
        byte_pos = 0;
        pc_begin = 0;
        pc_end = 0;
        mode = SP_IDLE;
        letter_kind = K_LETTERS;
        nl_end = 0;
        nl_seen = 1'b0;
        tail_start = 0;
        tail_cnt = 0;
        tail_space = 1'b0;
        held = 0;
        num_cnt = 0;
    endfunction

    function automatic void predict_pieces(logic [7:0] b, bit fin);
        int n;
        int unsigned c;
        longint unsigned s, e;
        step_pieces.delete();
        if (win_cnt == 0) win_base = byte_pos;
        if (win_cnt < 8) begin
            win[win_cnt] = b;
            win_cnt++;
        end
        byte_pos = sat_inc(byte_pos, 1);
        forever begin
            n = unit_len(fin);
            if (n == 0 || n > win_cnt) break;
            c = unit_cp(n);
            s = win_base;
            e = sat_inc(win_base, n);
            for (int i = 0; i < 8; i++) win[i] = (i + n < 8) ? win[i + n] : 8'h00;
            win_cnt -= n;
            win_base = e;
            take_unit(c, s, e);
        end
        if (fin) begin
            case (mode)
                SP_LETTERS:   add_piece(pc_begin, pc_end, letter_kind);
                SP_NUMBERS:   add_piece(pc_begin, pc_end, K_NUMBERS);
                SP_OTHERS, SP_OTHERS_NL, SP_OPEN, SP_APOS:
                              add_piece(pc_begin, pc_end, K_OTHERS);
                SP_APOS2:     add_piece(pc_begin, pc_end, K_PREFIXED);
                SP_WS:        ws_close(1'b0, 0, 0, 0);
                default: ;
            endcase
            if (step_pieces.size() > 0) step_pieces[$].done = 1'b1;
            clear_splitter();
        end
        if (step_pieces.size() > 0) step_pieces[$].last = 1'b1;
        foreach (step_pieces[i]) pending_pieces.insert(pending_pieces.size(), step_pieces[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_word(logic [7:0] b, bit fin);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        predict_pieces(b, fin);
        sent_words++;
    endtask

    task automatic send_text(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_word(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic void push_utf8(ref logic [7:0] q[$], input int unsigned c);
        if (c < 32'h80) begin
            q.insert(q.size(), c[7:0]);
        end else if (c < 32'h800) begin
            q.insert(q.size(), 8'hC0 | {3'b000, c[10:6]});
            q.insert(q.size(), 8'h80 | {2'b00, c[5:0]});
        end else if (c < 32'h10000) begin
            q.insert(q.size(), 8'hE0 | {4'h0, c[15:12]});
            q.insert(q.size(), 8'h80 | {2'b00, c[11:6]});
            q.insert(q.size(), 8'h80 | {2'b00, c[5:0]});
        end else begin
            q.insert(q.size(), 8'hF0 | {5'b00000, c[20:18]});
            q.insert(q.size(), 8'h80 | {2'b00, c[17:12]});
            q.insert(q.size(), 8'h80 | {2'b00, c[11:6]});
            q.insert(q.size(), 8'h80 | {2'b00, c[5:0]});
        end
    endfunction

    function automatic void push_token(ref logic [7:0] q[$]);
        int unsigned cps[] = '{32'hE9, 32'h430, 32'h4E2D, 32'hAC00, 32'h3042, 32'h661,
            32'hFF11, 32'h1D7CE, 32'h1D7FF, 32'h3000, 32'h2003, 32'hA0, 32'h85, 32'h20AC,
            32'h1F600, 32'hD7FF, 32'h10FFFF, 32'h966, 32'h2028, 32'hFFFF};
        string apos[] = '{"s", "T", "m", "D", "re", "VE", "ll", "lL", "x", "r", "v", "l"};
        string punct = "!?.,;:-()\"#$%&*+/<=>@[]_{}~";
        string sfx;
        int len;
        case ($urandom_range(0, 11))
            0, 1: begin
                len = $urandom_range(1, 6);
                repeat (len) q.insert(q.size(), $urandom_range(0, 1) ?
                    8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z")));
            end
            2: repeat ($urandom_range(1, 5)) q.insert(q.size(), 8'($urandom_range("0", "9")));
            3: repeat ($urandom_range(1, 3)) q.insert(q.size(), 8'h20);
            4: repeat ($urandom_range(1, 2))
                   q.insert(q.size(), $urandom_range(0, 1) ? 8'h0A : 8'h0D);
            5: begin
                sfx = apos[$urandom_range(0, apos.size() - 1)];
                q.insert(q.size(), 8'h27);
                for (int i = 0; i < sfx.len(); i++) q.insert(q.size(), sfx[i]);
            end
            6: repeat ($urandom_range(1, 3))
                   q.insert(q.size(), punct[$urandom_range(0, punct.len() - 1)]);
            7, 8: push_utf8(q, cps[$urandom_range(0, cps.size() - 1)]);
            9: q.insert(q.size(), $urandom_range(0, 1) ? 8'h09 : 8'($urandom_range(8'h0B, 8'h0C)));
            default: q.insert(q.size(), 8'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic test_contractions();
        send_text('{"'", "s", "'", "T", "'", "r", "E", "'", "V", "e", "'", "l", "l",
                    "'", "x", "'", "r"});
    endtask

    task automatic test_classes();
        send_text('{" ", "a", "1", "2", "3", "4", " ", "!", "?", 8'h0D, 8'h0A, " ", " ",
                    8'h0A, " ", "b", 8'h00, 8'hFF});
    endtask

    task automatic test_utf8();
        send_text('{8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9D, 8'h9F, 8'h8E, 8'hED, 8'hA0, 8'h80,
                    8'hC0, 8'hF5, 8'hE4, 8'hB8});
    endtask

    task automatic test_random_text();
        logic [7:0] text[$];
        int toks;
        int lucky;
        lucky = 0;
        while (sent_words < 350) begin
            text.delete();
            toks = $urandom_range(1, 12);
            repeat (toks) begin
                if ($urandom_range(0, 9) < 9) begin
                    // apostrophe suffixes, some of them not contractions
                    if ($urandom_range(0, 6) == 0) begin
                        text.insert(text.size(), "'");
                        case ($urandom_range(0, 6))
                            0: text.insert(text.size(), "s");
                            1: text.insert(text.size(), "T");
                            2: begin
                                text.insert(text.size(), "r");
                                text.insert(text.size(), "E");
                            end
                            3: begin
                                text.insert(text.size(), "v");
                                text.insert(text.size(), "e");
                            end
                            4: begin
                                text.insert(text.size(), "L");
                                text.insert(text.size(), "l");
                            end
                            5: begin
                                text.insert(text.size(), "l");
                                text.insert(text.size(), "x");
                            end
                            default: text.insert(text.size(), "q");
                        endcase
                    end else begin
                        push_token(text);
                    end
                end else begin
                    text.insert(text.size(), 8'($urandom_range(8'h80, 8'hFF)));
                end
            end
            no_idle = ($urandom_range(0, 4) == 0);
            send_text(text);
            lucky++;
            if (lucky == 3) wait_drained();
        end
        no_idle = 1'b0;
    endtask

    always begin
        int gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_m_tready <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_piece want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pieces.size() == 0) begin
                $error("piece with none expected: start %0d", o_m_tdata[31:0]);
                fail_count++;
            end else begin
                want = pending_pieces.pop_front();
                if (o_m_tdata[31:0] !== want.start) begin
                    $error("piece_start exp %0d got %0d", want.start, o_m_tdata[31:0]);
                    fail_count++;
                end
                if (o_m_tdata[63:32] !== want.length) begin
                    $error("piece_length exp %0d got %0d", want.length, o_m_tdata[63:32]);
                    fail_count++;
                end
                if (o_m_tdata[66:64] !== want.kind) begin
                    $error("piece_kind exp %0d got %0d", want.kind, o_m_tdata[66:64]);
                    fail_count++;
                end
                if (o_m_tlast !== want.done) begin
                    $error("text_done exp %0d got %0d", want.done, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tuser[0] !== want.last) begin
                    $error("last_of_run exp %0d got %0d", want.last, o_m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        clear_splitter();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_contractions();
        test_classes();
        test_utf8();
        test_random_text();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_pieces.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
